// File: rtl/redundant_sensor_window_average_macros.svh
`ifndef REDUNDANT_SENSOR_WINDOW_AVERAGE_MACROS_SVH
`define REDUNDANT_SENSOR_WINDOW_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSWA_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rswa: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSWA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rswa: assertion failed");

`endif

// File: rtl/rswa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rswa_pkg;

    localparam int CHAN_W          = 2;
    localparam int READING_INPUTS  = 3;
    localparam int JOB_QUEUE_DEPTH = 2;

    // x / 3 == (x * RECIP_3) >> RECIP_3_SHIFT for any 32-bit unsigned x
    localparam logic [31:0] RECIP_3       = 32'hAAAA_AAAB;
    localparam int          RECIP_3_SHIFT = 33;

    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic signed [31:0] reading_a;
        logic signed [31:0] reading_b;
        logic signed [31:0] reading_c;
        logic [2:0]         fault_mask;
        logic               update;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_channel;
        logic signed [31:0] window_mean;
        logic               no_healthy;
    } t_out_item;

    // Classified transaction handed from the front end to the window engine
    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic               in_range;
        logic               do_write;
        logic               no_healthy;
        logic signed [31:0] fused;
    } t_job;

endpackage

`default_nettype wire

// File: rtl/rswa_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rswa_front #(
    parameter int SENSOR_COUNT  = 3,
    parameter int CHANNEL_COUNT = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rswa_pkg::t_in_item i_in_data,
    output logic                    o_job_valid,
    input  wire logic               i_job_ready,
    output rswa_pkg::t_job          o_job
);

    localparam int SN = (SENSOR_COUNT < rswa_pkg::READING_INPUTS) ?
                        SENSOR_COUNT : rswa_pkg::READING_INPUTS;
    localparam logic [1:0] LAST_IDX = 2'(SN);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_PUSH
    } t_state;

    function automatic logic [2:0] healthy_bits(input logic [2:0] mask);
        logic [2:0] h;
        for (int i = 0; i < 3; i++) begin
            h[i] = (i < SN) && !mask[i];
        end
        return h;
    endfunction

    t_state              r_state;
    rswa_pkg::t_in_item  r_item;
    logic [1:0]          r_idx;
    logic [1:0]          r_div;
    logic                r_pv;
    logic                r_use;
    logic                r_neg;
    logic [63:0]         r_prod;
    logic signed [31:0]  r_acc;
    logic                r_in_range;
    logic                r_do_write;
    logic                r_no_healthy;

    logic [2:0]  w_in_h;
    logic [1:0]  w_in_count;
    logic        w_in_range;
    logic        w_in_write;
    logic        w_in_flag;
    logic [2:0]  w_h;
    logic [31:0] w_rd;
    logic        w_neg;
    logic [31:0] w_mag;
    logic [31:0] w_mulk;
    logic [63:0] w_prod;
    logic [63:0] w_shifted;
    logic [31:0] w_q;
    logic [31:0] w_sq;

    assign w_in_h     = healthy_bits(i_in_data.fault_mask);
    assign w_in_count = 2'(w_in_h[0]) + 2'(w_in_h[1]) + 2'(w_in_h[2]);
    assign w_in_range = (int'(i_in_data.channel) < CHANNEL_COUNT);
    assign w_in_write = w_in_range && i_in_data.update && (w_in_count != 2'd0);
    assign w_in_flag  = w_in_range && i_in_data.update && (w_in_count == 2'd0);

    assign w_h = healthy_bits(r_item.fault_mask);

    always_comb begin
        unique case (r_idx)
            2'd0:    w_rd = r_item.reading_a;
            2'd1:    w_rd = r_item.reading_b;
            2'd2:    w_rd = r_item.reading_c;
            default: w_rd = '0;
        endcase
    end

    // Sign-magnitude divide by the healthy count, truncating toward zero
    assign w_neg  = w_rd[31];
    assign w_mag  = w_neg ? (~w_rd + 32'd1) : w_rd;
    assign w_mulk = (r_div == 2'd3) ? rswa_pkg::RECIP_3 : 32'd1;
    assign w_prod = w_mag * w_mulk;

    always_comb begin
        unique case (r_div)
            2'd2:    w_shifted = r_prod >> 1;
            2'd3:    w_shifted = r_prod >> rswa_pkg::RECIP_3_SHIFT;
            default: w_shifted = r_prod;
        endcase
    end

    assign w_q  = w_shifted[31:0];
    assign w_sq = r_neg ? (32'd0 - w_q) : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item       <= i_in_data;
                        r_idx        <= '0;
                        r_pv         <= 1'b0;
                        r_acc        <= '0;
                        r_div        <= w_in_count;
                        r_in_range   <= w_in_range;
                        r_do_write   <= w_in_write;
                        r_no_healthy <= w_in_flag;
                        r_state      <= w_in_write ? S_CALC : S_PUSH;
                    end
                end
                S_CALC: begin
                    if (r_idx != LAST_IDX) begin
                        r_prod <= w_prod;
                        r_neg  <= w_neg;
                        r_use  <= w_h[r_idx];
                        r_pv   <= 1'b1;
                        r_idx  <= r_idx + 2'd1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && r_use) begin
                        r_acc <= r_acc + signed'(w_sq);
                    end
                    if ((r_idx == LAST_IDX) && !r_pv) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_PUSH);

    always_comb begin
        o_job.channel    = r_item.channel;
        o_job.in_range   = r_in_range;
        o_job.do_write   = r_do_write;
        o_job.no_healthy = r_no_healthy;
        o_job.fused      = r_acc;
    end

endmodule

`default_nettype wire

// File: rtl/rswa_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rswa_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr_valid,
    output logic                o_wr_ready,
    input  wire rswa_pkg::t_job i_wr_data,
    output logic                o_rd_valid,
    input  wire logic           i_rd_ready,
    output rswa_pkg::t_job      o_rd_data
);

    localparam int DEPTH = rswa_pkg::JOB_QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    rswa_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    logic w_push;
    logic w_pop;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CW'(w_push) - CW'(w_pop);
        end
    end

endmodule

`default_nettype wire

// File: rtl/rswa_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rswa_back #(
    parameter int WINDOW_DEPTH  = 10,
    parameter int CHANNEL_COUNT = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    output logic                o_job_ready,
    input  wire rswa_pkg::t_job i_job,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output rswa_pkg::t_out_item o_out_data
);

    localparam int PTR_W     = $clog2(WINDOW_DEPTH);
    localparam int SUM_W     = 32 + PTR_W;
    localparam int MAX_CH    = 1 << rswa_pkg::CHAN_W;
    localparam int NUM_CH    = (CHANNEL_COUNT < MAX_CH) ? CHANNEL_COUNT : MAX_CH;
    localparam int CH_IW     = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int ADDR_W    = CH_IW + PTR_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int DIG       = 8;
    localparam int DIV_STEPS = (SUM_W + DIG - 1) / DIG;
    localparam int PAD_W     = DIV_STEPS * DIG;
    localparam int REM_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam logic [REM_W:0]   DEN      = (REM_W + 1)'(WINDOW_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_OUT
    } t_state;

    logic signed [31:0]      r_ring [MEM_DEPTH];
    logic signed [31:0]      r_rdata;
    logic [PTR_W-1:0]        r_ptr [NUM_CH];
    logic                    r_wrapped [NUM_CH];
    logic signed [SUM_W-1:0] r_sum [NUM_CH];

    t_state                  r_state;
    rswa_pkg::t_job          r_job;
    logic [PAD_W-1:0]        r_dvd;
    logic [PAD_W-1:0]        r_quo;
    logic [REM_W-1:0]        r_rem;
    logic                    r_neg;
    logic [STEP_W-1:0]       r_step;
    rswa_pkg::t_out_item     r_out;

    logic [CH_IW-1:0]        w_in_ch;
    logic [ADDR_W-1:0]       w_raddr;
    logic [CH_IW-1:0]        w_ch;
    logic [ADDR_W-1:0]       w_waddr;
    logic                    w_mem_we;
    logic signed [31:0]      w_old;
    logic signed [SUM_W-1:0] w_new_sum;
    logic signed [SUM_W-1:0] w_dividend;
    logic [SUM_W-1:0]        w_abs;
    logic [REM_W:0]          w_trial;
    logic [REM_W-1:0]        w_rem;
    logic [DIG-1:0]          w_qd;
    logic [PAD_W-1:0]        w_quo_full;
    logic [31:0]             w_q32;

    assign w_in_ch  = i_job.channel[CH_IW-1:0];
    assign w_raddr  = {w_in_ch, r_ptr[w_in_ch]};
    assign w_ch     = r_job.channel[CH_IW-1:0];
    assign w_waddr  = {w_ch, r_ptr[w_ch]};
    assign w_mem_we = (r_state == S_READ) && r_job.do_write;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_ring[w_waddr] <= r_job.fused;
        end
        r_rdata <= r_ring[w_raddr];
    end

    // Slots not yet written since reset count as zero
    assign w_old      = r_wrapped[w_ch] ? r_rdata : 32'sd0;
    assign w_new_sum  = r_sum[w_ch] - SUM_W'(w_old) + SUM_W'(r_job.fused);
    assign w_dividend = !r_job.in_range ? '0 :
                        (r_job.do_write ? w_new_sum : r_sum[w_ch]);
    assign w_abs      = w_dividend[SUM_W-1] ? (SUM_W'(0) - w_dividend) : w_dividend;

    // Restoring division by the window depth, one byte of dividend per cycle
    always_comb begin
        w_rem   = r_rem;
        w_qd    = '0;
        w_trial = '0;
        for (int k = 0; k < DIG; k++) begin
            w_trial = {w_rem, r_dvd[PAD_W-1-k]};
            if (w_trial >= DEN) begin
                w_trial        = w_trial - DEN;
                w_qd[DIG-1-k]  = 1'b1;
            end
            w_rem = w_trial[REM_W-1:0];
        end
    end

    assign w_quo_full = {r_quo[PAD_W-DIG-1:0], w_qd};
    assign w_q32      = w_quo_full[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int c = 0; c < NUM_CH; c++) begin
                r_ptr[c]     <= '0;
                r_wrapped[c] <= 1'b0;
                r_sum[c]     <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_job.do_write) begin
                        r_sum[w_ch] <= w_new_sum;
                        if (r_ptr[w_ch] == PTR_LAST) begin
                            r_ptr[w_ch]     <= '0;
                            r_wrapped[w_ch] <= 1'b1;
                        end else begin
                            r_ptr[w_ch] <= r_ptr[w_ch] + PTR_W'(1);
                        end
                    end
                    r_neg   <= w_dividend[SUM_W-1];
                    r_dvd   <= PAD_W'(w_abs);
                    r_quo   <= '0;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_rem;
                    r_quo  <= w_quo_full;
                    r_dvd  <= r_dvd << DIG;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_out.out_channel <= r_job.channel;
                        r_out.window_mean <= r_neg ? (32'd0 - w_q32) : w_q32;
                        r_out.no_healthy  <= r_job.no_healthy;
                        r_state           <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_job_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/redundant_sensor_window_average.sv
// Fault-masked mean of redundant sensor readings with a per-channel moving average.
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction carries a
// channel, three redundant readings, a fault mask and an update flag.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one transaction
// per input, in order, with the channel, the window average and the no_healthy flag.
// The front end divides each healthy reading by the healthy count on one shared
// multiplier, one sensor per cycle; a transaction that writes nothing skips it.
// A two-entry queue feeds the window engine, which reads and writes the ring memory
// and divides the window sum by WINDOW_DEPTH a byte per cycle.
// The window engine sets throughput: it takes no new transaction until it has
// handed its last result to the receiver.
// Reset clears ring pointers, window sums and all control; the ring memory itself is
// not cleared, since per-channel wrap flags make unwritten slots read as zero.
// A stalled receiver holds the result in the output register; the front end keeps
// taking transactions until the queue fills, then o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module redundant_sensor_window_average #(
    parameter int WINDOW_DEPTH  = 10,
    parameter int SENSOR_COUNT  = 3,
    parameter int CHANNEL_COUNT = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire rswa_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output rswa_pkg::t_out_item      o_out_data
);

    logic           w_fr_valid;
    logic           w_fr_ready;
    rswa_pkg::t_job w_fr_job;
    logic           w_bk_valid;
    logic           w_bk_ready;
    rswa_pkg::t_job w_bk_job;

    rswa_front #(
        .SENSOR_COUNT  (SENSOR_COUNT),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (w_fr_valid),
        .i_job_ready (w_fr_ready),
        .o_job       (w_fr_job)
    );

    rswa_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fr_valid),
        .o_wr_ready (w_fr_ready),
        .i_wr_data  (w_fr_job),
        .o_rd_valid (w_bk_valid),
        .i_rd_ready (w_bk_ready),
        .o_rd_data  (w_bk_job)
    );

    rswa_back #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_bk_valid),
        .o_job_ready (w_bk_ready),
        .i_job       (w_bk_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: rtl/rswa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "redundant_sensor_window_average_macros.svh"

module rswa_checker #(
    parameter int CHANNEL_COUNT   = 4,
    parameter int MAX_OUTSTANDING = 4
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire rswa_pkg::t_in_item  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire rswa_pkg::t_out_item o_out_data
);

    localparam int PW = $clog2(MAX_OUTSTANDING + 1);

    logic [PW-1:0]               r_pending;
    logic [rswa_pkg::CHAN_W-1:0] r_last_ch;
    logic                        w_in_acc;
    logic                        w_out_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + PW'(w_in_acc) - PW'(w_out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_last_ch <= i_in_data.channel;
        end
    end

    `RSWA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `RSWA_ASSERT_NOW(a_no_orphan, i_clk, i_rst_n, o_out_valid, r_pending != '0)
    `RSWA_ASSERT_NOW(a_bounded, i_clk, i_rst_n, o_in_ready, r_pending < PW'(MAX_OUTSTANDING))
    `RSWA_ASSERT_NOW(a_order, i_clk, i_rst_n, o_out_valid && (r_pending == PW'(1)), o_out_data.out_channel == r_last_ch)
    `RSWA_ASSERT_NOW(a_out_range, i_clk, i_rst_n, o_out_valid && (int'(o_out_data.out_channel) >= CHANNEL_COUNT), (o_out_data.window_mean == 32'sd0) && !o_out_data.no_healthy)

endmodule

bind redundant_sensor_window_average rswa_checker #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
) u_rswa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// File: test/rswa_window_checker.sv
`timescale 1ns / 1ps

module rswa_window_checker #(
    parameter int WINDOW_DEPTH  = 10,
    parameter int CHANNEL_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  rswa_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  rswa_pkg::t_out_item i_out_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked
);
    import rswa_pkg::*;

    localparam int SENSORS = 3;

    longint    ring[CHANNEL_COUNT][WINDOW_DEPTH];
    int        ring_slot[CHANNEL_COUNT];
    longint    window_total[CHANNEL_COUNT];
    t_out_item expected_results[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t: mismatch on %s in result %0d: got %0d, expected %0d",
                 $realtime, field, o_checked, got, want);
        o_errors++;
    endtask

    function automatic void clear_windows();
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            for (int s = 0; s < WINDOW_DEPTH; s++) begin
                ring[c][s] = 0;
            end
            ring_slot[c]    = 0;
            window_total[c] = 0;
        end
    endfunction

    // Fused mean of the healthy sensors, pushed into the channel window on an update with a healthy sensor.
    function automatic t_out_item fuse_and_average(input t_in_item it);
        t_out_item          r;
        logic signed [31:0] rd[SENSORS];
        int                 healthy;
        int                 ch;
        int                 slot;
        longint             fused;
        longint             avg;
        rd[0] = it.reading_a;
        rd[1] = it.reading_b;
        rd[2] = it.reading_c;
        ch    = int'(it.channel);
        r.out_channel = it.channel;
        r.no_healthy  = 1'b0;
        r.window_mean = '0;
        if (ch < CHANNEL_COUNT) begin
            if (it.update) begin
                healthy = 0;
                for (int i = 0; i < SENSORS; i++) begin
                    if (!it.fault_mask[i]) healthy++;
                end
                if (healthy == 0) begin
                    r.no_healthy = 1'b1;
                end else begin
                    fused = 0;
                    for (int i = 0; i < SENSORS; i++) begin
                        if (!it.fault_mask[i]) fused += longint'(rd[i]) / longint'(healthy);
                    end
                    slot = ring_slot[ch];
                    window_total[ch] = window_total[ch] - ring[ch][slot] + fused;
                    ring[ch][slot]   = fused;
                    ring_slot[ch]    = (slot == WINDOW_DEPTH - 1) ? 0 : slot + 1;
                end
            end
            avg = window_total[ch] / longint'(WINDOW_DEPTH);
            r.window_mean = avg[31:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_windows();
            expected_results.delete();
        end else begin
            // compare before pushing so a same-edge input never matches its own result
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("outstanding transactions", 0, 1);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.out_channel !== want.out_channel)
                        report_mismatch("out_channel", i_out_data.out_channel, want.out_channel);
                    if (i_out_data.window_mean !== want.window_mean)
                        report_mismatch("window_mean", i_out_data.window_mean, want.window_mean);
                    if (i_out_data.no_healthy !== want.no_healthy)
                        report_mismatch("no_healthy", i_out_data.no_healthy, want.no_healthy);
                end
                o_checked++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(fuse_and_average(i_in_data));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: test/redundant_sensor_window_average_tb.sv
`timescale 1ns / 1ps

module redundant_sensor_window_average_tb;
    import rswa_pkg::*;

    localparam logic [1:0] CH_ACCEL_X  = 2'd0;
    localparam logic [1:0] CH_ACCEL_Y  = 2'd1;
    localparam logic [1:0] CH_ACCEL_Z  = 2'd2;
    localparam logic [1:0] CH_PRESSURE = 2'd3;
    localparam logic [2:0] ALL_HEALTHY = 3'b000;
    localparam logic [2:0] ONLY_A      = 3'b110;
    localparam logic [2:0] ALL_FAULTY  = 3'b111;

    localparam logic signed [31:0] READ_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] READ_MIN = 32'sh8000_0000;

    localparam int RANDOM_ITEMS = 1550;
    localparam int IDLE_PCT     = 9;
    localparam int TAIL_CYCLES  = 30;
    localparam int STALL_LIMIT  = 2000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    logic      no_gaps   = 1'b0;
    int        errors;
    int        pending;
    int        checked;
    int        stall_cycles = 0;
    int        n_updates    = 0;
    int        n_skipped    = 0;
    int        n_reads      = 0;

    always #5 clk = ~clk;

    redundant_sensor_window_average dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    rswa_window_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    always @(posedge clk) begin
        out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d results pending",
                         stall_cycles, pending);
                $display("redundant_sensor_window_average_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic t_in_item make_item(input logic [1:0] ch,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic signed [31:0] c,
                                           input logic [2:0] mask, input logic upd);
        t_in_item it;
        it.channel    = ch;
        it.reading_a  = a;
        it.reading_b  = b;
        it.reading_c  = c;
        it.fault_mask = mask;
        it.update     = upd;
        return it;
    endfunction

    function automatic logic signed [31:0] pick_reading();
        case ($urandom_range(0, 9))
            0:       return READ_MAX;
            1:       return READ_MIN;
            2:       return 32'($urandom_range(0, 200)) - 32'sd100;
            3:       return 32'($urandom_range(0, 2)) - 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send(input t_in_item it);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        if (!it.update) n_reads++;
        else if (it.fault_mask == ALL_FAULTY) n_skipped++;
        else n_updates++;
    endtask

    initial begin
        t_in_item it;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // averages straight after reset
        for (int ch = 0; ch < 4; ch++) begin
            send(make_item(2'(ch), pick_reading(), pick_reading(), pick_reading(),
                           3'($urandom_range(0, 7)), 1'b0));
        end
        // fill the pressure window with full-scale samples and wrap once
        repeat (11) send(make_item(CH_PRESSURE, READ_MAX, READ_MIN, READ_MIN, ONLY_A, 1'b1));
        // every fault mask on accel x, all faulty included
        for (int m = 0; m < 8; m++) begin
            send(make_item(CH_ACCEL_X, READ_MAX, READ_MIN, -32'sd1, 3'(m), 1'b1));
        end
        send(make_item(CH_ACCEL_Y, READ_MIN, READ_MIN, READ_MIN, ALL_HEALTHY, 1'b1));
        send(make_item(CH_ACCEL_Y, READ_MIN, READ_MIN, READ_MIN, ALL_FAULTY, 1'b0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_gaps <= (n >= 300 && n < 600);
            if (n == 800) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            it = make_item(2'($urandom_range(CH_ACCEL_X, CH_PRESSURE)), pick_reading(),
                           pick_reading(), pick_reading(), 3'($urandom_range(0, 7)),
                           $urandom_range(0, 99) < 75);
            send(it);
        end
        in_valid <= 1'b0;
        no_gaps  <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d window updates, %0d all-faulty skips, %0d read-only lookups",
                 n_updates, n_skipped, n_reads);
        $display("%0d results checked across channels x, y, z and pressure, %0d mismatches",
                 checked, errors);
        if (errors == 0) begin
            $display("redundant_sensor_window_average_tb: done, clean");
        end else begin
            $display("redundant_sensor_window_average_tb: done, errors");
        end
        $finish;
    end

endmodule
